// ----- src/pfv_pkg.sv -----
// Package for the potential-field velocity step: register map, reset values,
// configuration and pipeline tag structs. No dependencies.
`default_nettype none

package pfv_pkg;

    localparam int ADDR_W      = 5;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_TARGET_X      = 3'd1,
        REG_TARGET_Y      = 3'd2,
        REG_GAIN          = 3'd3,
        REG_MAX_SPEED     = 3'd4,
        REG_TIME_STEP     = 3'd5,
        REG_ARRIVE_RADIUS = 3'd6
    } pfv_reg_t;

    localparam logic [15:0] GAIN_RST   = 16'd256;
    localparam logic [30:0] SPEED_RST  = 31'd65536;
    localparam logic [15:0] STEP_RST   = 16'd131;
    localparam logic [30:0] RADIUS_RST = 31'd6554;

    typedef struct packed {
        logic        enable;
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [15:0] attract_gain;
        logic [30:0] max_speed;
        logic [15:0] time_step;
        logic [30:0] arrive_radius;
    } pfv_cfg_t;

    // Side data that rides along the square root and divider pipelines
    typedef struct packed {
        logic [30:0] a;
        logic [30:0] b;
        logic        clamp;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        arrived;
    } pfv_tag_t;

endpackage

`default_nettype wire

// ----- src/pfv_cfg.sv -----
// APB register file for the potential-field velocity step.
// Depends on pfv_pkg.
`default_nettype none

module pfv_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [pfv_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output pfv_pkg::pfv_cfg_t              cfg
);
    import pfv_pkg::*;

    pfv_cfg_t cfg_reg;
    pfv_cfg_t cfg_next;
    pfv_reg_t idx;

    assign idx    = pfv_reg_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode a write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                REG_ENABLE:        cfg_next.enable        = pwdata[0];
                REG_TARGET_X:      cfg_next.target_x      = pwdata;
                REG_TARGET_Y:      cfg_next.target_y      = pwdata;
                REG_GAIN:          cfg_next.attract_gain  = pwdata[15:0];
                REG_MAX_SPEED:     cfg_next.max_speed     = pwdata[30:0];
                REG_TIME_STEP:     cfg_next.time_step     = pwdata[15:0];
                REG_ARRIVE_RADIUS: cfg_next.arrive_radius = pwdata[30:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.target_x      <= '0;
            cfg_reg.target_y      <= '0;
            cfg_reg.attract_gain  <= GAIN_RST;
            cfg_reg.max_speed     <= SPEED_RST;
            cfg_reg.time_step     <= STEP_RST;
            cfg_reg.arrive_radius <= RADIUS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_ENABLE:        prdata = {31'd0, cfg_reg.enable};
            REG_TARGET_X:      prdata = cfg_reg.target_x;
            REG_TARGET_Y:      prdata = cfg_reg.target_y;
            REG_GAIN:          prdata = {16'd0, cfg_reg.attract_gain};
            REG_MAX_SPEED:     prdata = {1'b0, cfg_reg.max_speed};
            REG_TIME_STEP:     prdata = {16'd0, cfg_reg.time_step};
            REG_ARRIVE_RADIUS: prdata = {1'b0, cfg_reg.arrive_radius};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/pfv_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with a side tag.
// Depends on pfv_pkg.
`default_nettype none

module pfv_isqrt (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [62:0]      radicand,
    input  pfv_pkg::pfv_tag_t     in_tag,
    output logic                  out_vld,
    output logic [31:0]           root,
    output pfv_pkg::pfv_tag_t     out_tag
);
    import pfv_pkg::*;

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [33:0]            rem_reg  [SQRT_STAGES];
    logic [31:0]            root_reg [SQRT_STAGES];
    logic [63:0]            x_reg    [SQRT_STAGES];
    pfv_tag_t               tag_reg  [SQRT_STAGES];

    genvar i;
    generate
        for (i = 0; i < SQRT_STAGES; i++)
        begin : g_stage
            logic        vld_in;
            logic [33:0] rem_in;
            logic [31:0] root_in;
            logic [63:0] x_in;
            pfv_tag_t    tag_in;
            logic [35:0] rem_sh;
            logic [35:0] trial;
            logic [33:0] rem_next;
            logic [31:0] root_next;

            if (i == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = {1'b0, radicand};
                assign tag_in  = in_tag;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign x_in    = x_reg[i-1];
                assign tag_in  = tag_reg[i-1];
            end

            // Bring down two radicand bits and try the next root bit
            always_comb
            begin
                rem_sh = {rem_in, x_in[63-2*i -: 2]};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = 34'(rem_sh - trial);
                    root_next = {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[33:0];
                    root_next = {root_in[30:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en)
                    vld_reg[i] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                    x_reg[i]    <= x_in;
                    tag_reg[i]  <= tag_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[SQRT_STAGES-1];
    assign root    = root_reg[SQRT_STAGES-1];
    assign out_tag = tag_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- src/pfv_div.sv -----
// Pipelined two-lane restoring divider with a shared divisor, one quotient
// bit per stage; quotients are known to fit in 31 bits. Depends on pfv_pkg.
`default_nettype none

module pfv_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [61:0]      num_x,
    input  wire logic [61:0]      num_y,
    input  wire logic [31:0]      divisor,
    input  pfv_pkg::pfv_tag_t     in_tag,
    output logic                  out_vld,
    output logic [30:0]           quo_x,
    output logic [30:0]           quo_y,
    output pfv_pkg::pfv_tag_t     out_tag
);
    import pfv_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [31:0]           rx_reg  [DIV_STAGES];
    logic [31:0]           ry_reg  [DIV_STAGES];
    logic [30:0]           qx_reg  [DIV_STAGES];
    logic [30:0]           qy_reg  [DIV_STAGES];
    logic [30:0]           lx_reg  [DIV_STAGES];
    logic [30:0]           ly_reg  [DIV_STAGES];
    logic [31:0]           d_reg   [DIV_STAGES];
    pfv_tag_t              tag_reg [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_stage
            logic        vld_in;
            logic [31:0] rx_in, ry_in, d_in;
            logic [30:0] qx_in, qy_in, lx_in, ly_in;
            pfv_tag_t    tag_in;
            logic [32:0] tx, ty;
            logic [31:0] rx_next, ry_next;
            logic        bx, by;

            if (j == 0)
            begin : g_first
                assign vld_in = in_vld;
                assign rx_in  = {1'b0, num_x[61:31]};
                assign ry_in  = {1'b0, num_y[61:31]};
                assign qx_in  = '0;
                assign qy_in  = '0;
                assign lx_in  = num_x[30:0];
                assign ly_in  = num_y[30:0];
                assign d_in   = divisor;
                assign tag_in = in_tag;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[j-1];
                assign rx_in  = rx_reg[j-1];
                assign ry_in  = ry_reg[j-1];
                assign qx_in  = qx_reg[j-1];
                assign qy_in  = qy_reg[j-1];
                assign lx_in  = lx_reg[j-1];
                assign ly_in  = ly_reg[j-1];
                assign d_in   = d_reg[j-1];
                assign tag_in = tag_reg[j-1];
            end

            // Shift in the next numerator bit and subtract where it fits
            always_comb
            begin
                tx = {rx_in, lx_in[30-j]};
                ty = {ry_in, ly_in[30-j]};
                bx = (tx >= {1'b0, d_in});
                by = (ty >= {1'b0, d_in});
                rx_next = bx ? 32'(tx - {1'b0, d_in}) : tx[31:0];
                ry_next = by ? 32'(ty - {1'b0, d_in}) : ty[31:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else if (en)
                    vld_reg[j] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx_reg[j]  <= rx_next;
                    ry_reg[j]  <= ry_next;
                    qx_reg[j]  <= {qx_in[29:0], bx};
                    qy_reg[j]  <= {qy_in[29:0], by};
                    lx_reg[j]  <= lx_in;
                    ly_reg[j]  <= ly_in;
                    d_reg[j]   <= d_in;
                    tag_reg[j] <= tag_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[DIV_STAGES-1];
    assign quo_x   = qx_reg[DIV_STAGES-1];
    assign quo_y   = qy_reg[DIV_STAGES-1];
    assign out_tag = tag_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- src/potential_field_velocity_step.sv -----
// Top level of the potential-field velocity step: front stages, square root,
// divider, integration and output stage. Depends on pfv_pkg, pfv_cfg,
// pfv_isqrt and pfv_div.
//
//   port group   direction  handshake            payload
//   config       in/out     psel/penable/pready  paddr, pwdata, prdata
//   position     in         in_valid/in_stall    pos_x, pos_y
//   velocity     out        out_valid/out_stall  vel_x, vel_y, next_x, next_y, arrived
//
// One word enters per cycle while the output word is not held; the stages are six front stages, 32
// square root stages (one root bit each), one multiply stage, 31 divider
// stages (one quotient bit each), one integration multiply and the output.
// The whole pipeline advances together; it holds while the output word waits
// under out_stall, and in_stall is raised for exactly those cycles.
// Reset clears every valid bit and loads the register defaults.
// Words arriving while the enable register is clear are taken and dropped.
`default_nettype none

module potential_field_velocity_step (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfv_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [31:0]                pos_x,
    input  wire logic [31:0]                pos_y,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [31:0]                vel_x,
    output logic      [31:0]                vel_y,
    output logic      [31:0]                next_x,
    output logic      [31:0]                next_y,
    output logic                            arrived
);
    import pfv_pkg::*;

    pfv_cfg_t cfg;
    logic     en;

    pfv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance everything unless the output word is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 1: differences to the target
    logic        v1_reg;
    logic [32:0] dx1_reg, dy1_reg;
    logic [31:0] px1_reg, py1_reg;

    // Stage 2: magnitudes and signs
    logic        v2_reg;
    logic [31:0] ax2_reg, ay2_reg;
    logic        nx2_reg, ny2_reg;
    logic [31:0] px2_reg, py2_reg;

    // Stage 3: raw speeds and squared distances
    logic        v3_reg;
    logic [39:0] vx3_reg, vy3_reg;
    logic [61:0] sqx3_reg, sqy3_reg, rr3_reg;
    logic        big3_reg;
    logic        nx3_reg, ny3_reg;
    logic [31:0] px3_reg, py3_reg;

    // Stage 4: arrival test and range reduction
    logic        v4_reg;
    logic [30:0] a4_reg, b4_reg;
    logic        c4_reg, arr4_reg;
    logic        nx4_reg, ny4_reg;
    logic [31:0] px4_reg, py4_reg;
    logic [39:0] or_v;
    logic [3:0]  shamt;
    logic [39:0] a_sh, b_sh;
    logic [62:0] dist_sq;

    // Stage 5: squares
    logic        v5_reg;
    logic [61:0] aa5_reg, bb5_reg, mm5_reg;
    pfv_tag_t    t5_reg;

    // Stage 6: norm squared and clamp decision
    logic        v6_reg;
    logic [62:0] sq6_reg;
    pfv_tag_t    t6_reg;
    logic [62:0] sq_sum;
    pfv_tag_t    t6_next;

    always_comb
    begin
        or_v  = vx3_reg | vy3_reg;
        shamt = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (or_v[31+k])
                shamt = 4'(k + 1);
        end
        a_sh    = vx3_reg >> shamt;
        b_sh    = vy3_reg >> shamt;
        dist_sq = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
        sq_sum  = {1'b0, aa5_reg} + {1'b0, bb5_reg};
        t6_next = t5_reg;
        t6_next.clamp = t5_reg.clamp || (sq_sum > {1'b0, mm5_reg});
    end

    // Front valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && cfg.enable;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Front payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= {cfg.target_x[31], cfg.target_x} - {pos_x[31], pos_x};
            dy1_reg <= {cfg.target_y[31], cfg.target_y} - {pos_y[31], pos_y};
            px1_reg <= pos_x;
            py1_reg <= pos_y;

            nx2_reg <= dx1_reg[32];
            ny2_reg <= dy1_reg[32];
            ax2_reg <= dx1_reg[32] ? 32'(-dx1_reg) : dx1_reg[31:0];
            ay2_reg <= dy1_reg[32] ? 32'(-dy1_reg) : dy1_reg[31:0];
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;

            vx3_reg  <= 40'((48'(ax2_reg) * 48'(cfg.attract_gain)) >> 8);
            vy3_reg  <= 40'((48'(ay2_reg) * 48'(cfg.attract_gain)) >> 8);
            sqx3_reg <= 62'(ax2_reg[30:0]) * 62'(ax2_reg[30:0]);
            sqy3_reg <= 62'(ay2_reg[30:0]) * 62'(ay2_reg[30:0]);
            rr3_reg  <= 62'(cfg.arrive_radius) * 62'(cfg.arrive_radius);
            big3_reg <= ax2_reg[31] || ay2_reg[31];
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;

            a4_reg   <= a_sh[30:0];
            b4_reg   <= b_sh[30:0];
            c4_reg   <= (shamt != 4'd0);
            arr4_reg <= !big3_reg && (dist_sq < {1'b0, rr3_reg});
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;

            aa5_reg <= 62'(a4_reg) * 62'(a4_reg);
            bb5_reg <= 62'(b4_reg) * 62'(b4_reg);
            mm5_reg <= 62'(cfg.max_speed) * 62'(cfg.max_speed);
            t5_reg  <= '{a: a4_reg, b: b4_reg, clamp: c4_reg, neg_x: nx4_reg,
                         neg_y: ny4_reg, pos_x: px4_reg, pos_y: py4_reg,
                         arrived: arr4_reg};

            sq6_reg <= sq_sum;
            t6_reg  <= t6_next;
        end
    end

    // Norm of the reduced velocity
    logic        vs_vld;
    logic [31:0] vs_root;
    pfv_tag_t    vs_tag;

    pfv_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v6_reg),
        .radicand (sq6_reg),
        .in_tag   (t6_reg),
        .out_vld  (vs_vld),
        .root     (vs_root),
        .out_tag  (vs_tag)
    );

    // Stage 7: scale numerators by the speed limit
    logic        v7_reg;
    logic [61:0] pa7_reg, pb7_reg;
    logic [31:0] n7_reg;
    pfv_tag_t    t7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= vs_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa7_reg <= 62'(vs_tag.a) * 62'(cfg.max_speed);
            pb7_reg <= 62'(vs_tag.b) * 62'(cfg.max_speed);
            n7_reg  <= (vs_root == 32'd0) ? 32'd1 : vs_root;
            t7_reg  <= vs_tag;
        end
    end

    logic        dv_vld;
    logic [30:0] dv_qx, dv_qy;
    pfv_tag_t    dv_tag;

    pfv_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v7_reg),
        .num_x   (pa7_reg),
        .num_y   (pb7_reg),
        .divisor (n7_reg),
        .in_tag  (t7_reg),
        .out_vld (dv_vld),
        .quo_x   (dv_qx),
        .quo_y   (dv_qy),
        .out_tag (dv_tag)
    );

    // Stage 8: pick clamped or raw speed, integrate over the time step
    logic        v8_reg;
    logic [30:0] vm8x_reg, vm8y_reg;
    logic [30:0] dm8x_reg, dm8y_reg;
    pfv_tag_t    t8_reg;
    logic [30:0] vm_x, vm_y;
    logic [46:0] mx, my;

    always_comb
    begin
        vm_x = dv_tag.clamp ? dv_qx : dv_tag.a;
        vm_y = dv_tag.clamp ? dv_qy : dv_tag.b;
        mx   = 47'(vm_x) * 47'(cfg.time_step);
        my   = 47'(vm_y) * 47'(cfg.time_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vm8x_reg <= vm_x;
            vm8y_reg <= vm_y;
            dm8x_reg <= mx[46:16];
            dm8y_reg <= my[46:16];
            t8_reg   <= dv_tag;
        end
    end

    // Stage 9: signs, saturating position update, output word
    logic        v9_reg;
    logic [31:0] velx9_reg, vely9_reg, nx9_reg, ny9_reg;
    logic        arr9_reg;
    logic [32:0] sum_x, sum_y;
    logic [31:0] sat_x, sat_y;

    always_comb
    begin
        sum_x = {t8_reg.pos_x[31], t8_reg.pos_x}
              + (t8_reg.neg_x ? 33'(-{2'b00, dm8x_reg}) : {2'b00, dm8x_reg});
        sum_y = {t8_reg.pos_y[31], t8_reg.pos_y}
              + (t8_reg.neg_y ? 33'(-{2'b00, dm8y_reg}) : {2'b00, dm8y_reg});
        if (sum_x[32] != sum_x[31])
            sat_x = sum_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            sat_x = sum_x[31:0];
        if (sum_y[32] != sum_y[31])
            sat_y = sum_y[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            sat_y = sum_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else if (en)
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            velx9_reg <= t8_reg.neg_x ? 32'(-{1'b0, vm8x_reg}) : {1'b0, vm8x_reg};
            vely9_reg <= t8_reg.neg_y ? 32'(-{1'b0, vm8y_reg}) : {1'b0, vm8y_reg};
            nx9_reg   <= sat_x;
            ny9_reg   <= sat_y;
            arr9_reg  <= t8_reg.arrived;
        end
    end

    assign out_valid = v9_reg;
    assign vel_x     = velx9_reg;
    assign vel_y     = vely9_reg;
    assign next_x    = nx9_reg;
    assign next_y    = ny9_reg;
    assign arrived   = arr9_reg;

    // Input must be held off while the output word waits
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output word is held");

    // Free output side never blocks the input
    a_free_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output side free");

    // An enabled accepted word enters the first stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cfg.enable |=> v1_reg)
        else $error("accepted word lost at entry");

    // A clamped word never exceeds the speed limit
    a_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld && dv_tag.clamp |-> (dv_qx <= cfg.max_speed) && (dv_qy <= cfg.max_speed))
        else $error("clamped speed above limit");

endmodule

`default_nettype wire
